// ===== hdl/lkv_pkg.sv =====
// shared types and constants for the lru key-value cache
// no dependencies; imported by every module of the block
package lkv_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 31;
    localparam int LIMIT_BITS = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] store_value;
    } lkv_req_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
    } lkv_rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } lkv_entry_t;

    typedef enum logic [1:0] {
        REC_NONE,
        REC_TOUCH,
        REC_EVICT,
        REC_INSERT
    } rec_op_t;

    typedef struct packed {
        rec_op_t          op;
        logic [IDX_W-1:0] slot;
    } rec_cmd_t;

    typedef struct packed {
        logic [CAPACITY-1:0] valid;
        logic [CNT_W-1:0]    occupancy;
        logic [IDX_W-1:0]    free_slot;
    } rec_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EVICT,
        ST_RESP
    } lkv_state_t;

endpackage

// ===== hdl/lru_key_value_cache_core.sv =====
// top level of the lru key-value cache: sequencer, request and response registers
// depends on lkv_pkg, lkv_entry_ram and lkv_recency
//
// Fully associative key-value cache of CAPACITY slots that keeps at most
// entry_limit entries (a limit of zero acts as one, above CAPACITY as
// CAPACITY) and replaces the least recently used entry. Keys and values sit
// in a single-port-read synchronous ram; valid bits and recency ranks sit in
// flip-flops. One transaction is handled at a time: a get or put is
// accepted only while the sequencer is idle, then the ram is scanned one
// slot per cycle, which sets the rate. A get waits to load its response
// register for as long as the previous response is still stalled. A put
// on a new key first evicts least recently used entries one at a time
// until occupancy is below the limit (normally at most one; more only
// after entry_limit was lowered), then inserts. A get always returns a
// response transaction: found=1 with the value, or found=0 with value 0.
// A put returns nothing. The response register decouples the output, so a
// new request is taken while a finished response waits. No clearing pass
// is needed after reset. Write entry_limit only while the block is idle.
module lru_key_value_cache_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  lkv_pkg::lkv_req_t                  req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output lkv_pkg::lkv_rsp_t                  rsp,
    input  logic                               cfg_wr_en,
    input  logic [lkv_pkg::LIMIT_BITS-1:0]     cfg_wr_data
);
    import lkv_pkg::*;

    lkv_state_t state_reg, state_next;

    // captured request and scan bookkeeping
    lkv_req_t               req_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [VALUE_BITS-1:0]  hit_value_reg;
    logic [LIMIT_BITS-1:0]  cfg_limit_reg;

    // response register
    logic                   rsp_valid_reg;
    lkv_rsp_t               rsp_reg;

    // ram and recency interface
    logic                   ram_rd_en;
    lkv_entry_t             ram_rd_data;
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    lkv_entry_t             ram_wr_data;
    rec_cmd_t               rec_cmd;
    rec_status_t            status;

    logic                   req_accept;
    logic                   rsp_load;
    logic                   scan_end;
    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W-1:0]       cmp_idx;
    logic                   key_match;
    logic [CNT_W-1:0]       eff_limit;
    logic                   need_evict;

    lkv_entry_ram u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    lkv_recency u_recency (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (rec_cmd),
        .status (status)
    );

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE);

    // the ram read issued at count k returns in the cycle at count k+1
    assign scan_end  = (32'(cnt_reg) == 32'(CAPACITY));
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cmp_idx   = cnt_m1[IDX_W-1:0];
    assign key_match = (cnt_reg != '0) && status.valid[cmp_idx]
                       && (ram_rd_data.key == req_reg.lookup_key);

    // clamp the programmed limit to 1 .. CAPACITY
    always_comb
    begin
        priority if (cfg_limit_reg == '0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (32'(cfg_limit_reg) > 32'(CAPACITY))
        begin
            eff_limit = CNT_W'(CAPACITY);
        end
        else
        begin
            eff_limit = CNT_W'(cfg_limit_reg);
        end
    end

    assign need_evict = (status.occupancy >= eff_limit) && (status.occupancy != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (req_reg.action == ACT_GET)
                begin
                    state_next = ST_RESP;
                end
                else if (hit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (!need_evict)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ram_rd_en         = 1'b0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = hit_idx_reg;
        ram_wr_data.key   = req_reg.lookup_key;
        ram_wr_data.value = req_reg.store_value;
        rec_cmd.op        = REC_NONE;
        rec_cmd.slot      = hit_idx_reg;
        rsp_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                ram_rd_en = !scan_end;
            end
            ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    rec_cmd.op = REC_TOUCH;
                    // update in place on a put hit
                    ram_wr_en  = (req_reg.action == ACT_PUT);
                end
            end
            ST_EVICT:
            begin
                if (need_evict)
                begin
                    rec_cmd.op = REC_EVICT;
                end
                else
                begin
                    rec_cmd.op   = REC_INSERT;
                    rec_cmd.slot = status.free_slot;
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = status.free_slot;
                end
            end
            ST_RESP:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            cfg_limit_reg <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cfg_limit_reg <= cfg_wr_data;
            end
            if (req_accept)
            begin
                cnt_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && !scan_end)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_SCAN && key_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_SCAN && key_match && !hit_reg)
        begin
            hit_idx_reg   <= cmp_idx;
            hit_value_reg <= ram_rd_data.value;
        end
        if (rsp_load)
        begin
            rsp_reg.found      <= hit_reg;
            rsp_reg.read_value <= hit_reg ? hit_value_reg : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // valid bit count and occupancy counter agree
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(status.valid) == 32'(status.occupancy))
        else $error("occupancy out of step with valid bits");

    // an insert only lands in a free slot
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        rec_cmd.op == REC_INSERT |-> !status.valid[rec_cmd.slot])
        else $error("insert into an occupied slot");

    // a hit recorded by the scan names a live entry
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE && hit_reg |-> status.valid[hit_idx_reg])
        else $error("hit on an invalid slot");

    // occupancy stays within the limit after any insert
    a_limit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rec_cmd.op == REC_INSERT |=> status.occupancy <= eff_limit)
        else $error("insert exceeded the entry limit");

    // a miss response carries a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.read_value == '0)
        else $error("miss response with nonzero value");
`endif

endmodule

// ===== hdl/lkv_entry_ram.sv =====
// key and value storage, one entry per slot, synchronous read
// depends on lkv_pkg
module lkv_entry_ram (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [lkv_pkg::IDX_W-1:0] rd_addr,
    output lkv_pkg::lkv_entry_t     rd_data,
    input  logic                    wr_en,
    input  logic [lkv_pkg::IDX_W-1:0] wr_addr,
    input  lkv_pkg::lkv_entry_t     wr_data
);
    import lkv_pkg::*;

    lkv_entry_t mem [CAPACITY];
    lkv_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lkv_recency.sv =====
// valid bits, recency ranks and occupancy count of the cache slots
// depends on lkv_pkg
module lkv_recency (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkv_pkg::rec_cmd_t     cmd,
    output lkv_pkg::rec_status_t  status
);
    import lkv_pkg::*;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]    rank_reg  [CAPACITY];
    logic [IDX_W-1:0]    rank_next [CAPACITY];
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [IDX_W-1:0]    touch_rank;
    logic [CNT_W-1:0]    occ_m1;
    logic [IDX_W-1:0]    victim;
    logic [IDX_W-1:0]    free_slot;
    logic                victim_hit;
    logic                free_hit;

    // least recent valid entry holds rank occupancy-1
    always_comb
    begin
        occ_m1     = occ_reg - CNT_W'(1);
        victim     = '0;
        victim_hit = 1'b0;
        free_slot  = '0;
        free_hit   = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!victim_hit && valid_reg[i] && rank_reg[i] == occ_m1[IDX_W-1:0])
            begin
                victim     = IDX_W'(i);
                victim_hit = 1'b1;
            end
            if (!free_hit && !valid_reg[i])
            begin
                free_slot = IDX_W'(i);
                free_hit  = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        touch_rank = rank_reg[cmd.slot];
        unique case (cmd.op)
            REC_NONE:
            begin
            end
            REC_TOUCH:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < touch_rank)
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[cmd.slot] = '0;
            end
            REC_EVICT:
            begin
                if (occ_reg != '0)
                begin
                    valid_next[victim] = 1'b0;
                    rank_next[victim]  = '0;
                    occ_next           = occ_m1;
                end
            end
            REC_INSERT:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                valid_next[cmd.slot] = 1'b1;
                rank_next[cmd.slot]  = '0;
                occ_next             = occ_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    assign status.valid     = valid_reg;
    assign status.occupancy = occ_reg;
    assign status.free_slot = free_slot;

endmodule
